>>> src/smkj_pkg.sv
// ---------------------------------------------------------------------------
// smkj_pkg: shared types and constants for the sort merge key join
// transfer payload structs, status codes and default sizes
// ---------------------------------------------------------------------------
package smkj_pkg;

  localparam int unsigned DEF_MAX_ROWS      = 1024;
  localparam int unsigned DEF_PAYLOAD_BYTES = 8;
  localparam int unsigned DEF_KEY_BITS      = 32;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_NO_MORE  = 2'd3;

  typedef struct packed {
    logic               action;
    logic signed [31:0] row_key;
    logic               is_left;
    logic        [63:0] row_payload;
    logic               last_row;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] left_payload;
    logic [63:0] right_payload;
    logic        last_match;
  } out_t;

endpackage

>>> src/smkj_ram.sv
// ---------------------------------------------------------------------------
// smkj_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module smkj_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/smkj_cmp.sv
// ---------------------------------------------------------------------------
// smkj_cmp: shared row order compare unit
// tells whether row b sorts ahead of row a
// ---------------------------------------------------------------------------
module smkj_cmp #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned PW       = 64,
  parameter int unsigned AW       = 10
) (
  input  logic [KEY_BITS-1:0] key_a,
  input  logic                side_a,
  input  logic [PW-1:0]       pay_a,
  input  logic [AW-1:0]       idx_a,
  input  logic [KEY_BITS-1:0] key_b,
  input  logic                side_b,
  input  logic [PW-1:0]       pay_b,
  input  logic [AW-1:0]       idx_b,
  output logic                b_first
);

  always_comb begin
    if (key_a != key_b) begin
      b_first = $signed(key_b) < $signed(key_a);
    end else if (side_a != side_b) begin
      // left rows go first on equal keys
      b_first = side_b;
    end else if (pay_a != pay_b) begin
      b_first = pay_b < pay_a;
    end else begin
      b_first = idx_b < idx_a;
    end
  end

endmodule

>>> src/sort_merge_key_join.sv
// ---------------------------------------------------------------------------
// sort_merge_key_join: equi join of two row sets by sorting and merging
// loads rows, merge sorts them with one compare unit, scans for key pairs
// ---------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid / stall | smkj_pkg::in_t
//  rsp     | out       | rsp_valid / stall | smkj_pkg::out_t
//
//  a read of a pair goes through the pair ram, then two row ram reads
//  through the single row ram read port
//  a row marked last starts the join: the order buffer is seeded, then
//  ceil(log2 n) merge passes run, then the scan runs; req_stall stays
//  high meanwhile
//  reset clears control state only, no ram clearing pass
//  a stalled response holds in the output register; a new request is taken
//  only when that register drains in the same cycle or is empty
module sort_merge_key_join #(
  parameter int unsigned MAX_ROWS      = smkj_pkg::DEF_MAX_ROWS,
  parameter int unsigned PAYLOAD_BYTES = smkj_pkg::DEF_PAYLOAD_BYTES,
  parameter int unsigned KEY_BITS      = smkj_pkg::DEF_KEY_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  smkj_pkg::in_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output smkj_pkg::out_t rsp
);
  import smkj_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned LW = AW + 2;
  localparam int unsigned PW = 8 * PAYLOAD_BYTES;
  localparam int unsigned RW = KEY_BITS + 1 + PW;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_INIT = 16'h0002,
    S_PASS = 16'h0004,
    S_MA   = 16'h0008,
    S_MB   = 16'h0010,
    S_MC   = 16'h0020,
    S_MD   = 16'h0040,
    S_ME   = 16'h0080,
    S_CW   = 16'h0100,
    S_JA   = 16'h0200,
    S_JB   = 16'h0400,
    S_JC   = 16'h0800,
    S_RA   = 16'h1000,
    S_RB   = 16'h2000,
    S_RC   = 16'h4000,
    S_RD   = 16'h8000
  } state_t;

  state_t state;

  // control registers
  logic [CW-1:0] rows_loaded;
  logic [CW-1:0] pairs_found;
  logic [CW-1:0] read_pointer;
  logic          joined;
  logic          src_sel;       // which order buffer holds the current pass
  logic          copy_from_q;
  logic          left_seen;
  logic [CW-1:0] cnt;           // seed and scan index
  logic [LW-1:0] width, lo, mid, hi, p, q, k;

  // datapath registers
  logic [AW-1:0]       idx_p, idx_q, cur_idx, scan_idx;
  logic [RW-1:0]       row_p;
  logic [KEY_BITS-1:0] cur_key;
  logic [PW-1:0]       left_pay;

  // ram ports
  logic          row_we;
  logic [AW-1:0] row_waddr, row_raddr;
  logic [RW-1:0] row_wdata, row_rdata;
  logic          ord_we, ord_wsel;
  logic [AW-1:0] ord_waddr, ord_raddr;
  logic [AW-1:0] ord_wdata, ord_a_rdata, ord_b_rdata, ord_rdata;
  logic          pair_we;
  logic [AW-1:0] pair_waddr;
  logic [2*AW-1:0] pair_wdata, pair_rdata;

  logic out_free, accept, b_first;
  logic [63:0]   key_ext;
  logic [CW-1:0] base_rows;
  logic          full;
  logic [LW-1:0] n_l, two_w;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) && out_free);
  assign accept    = req_valid && !req_stall;

  // key sign extended from bit 31 then wrapped to the stored key width
  assign key_ext   = 64'(signed'(req.row_key));
  assign base_rows = joined ? '0 : rows_loaded;
  assign full      = base_rows >= CW'(MAX_ROWS);
  assign n_l       = LW'(rows_loaded);
  assign two_w     = width << 1;
  assign ord_rdata = src_sel ? ord_b_rdata : ord_a_rdata;

  assign row_we    = accept && (req.action == ACT_LOAD) && !full;
  assign row_waddr = base_rows[AW-1:0];
  assign row_wdata = {key_ext[KEY_BITS-1:0], req.is_left, req.row_payload[PW-1:0]};

  always_comb begin
    case (state)
      S_MC:    row_raddr = idx_p;
      S_MD:    row_raddr = idx_q;
      S_JB:    row_raddr = ord_rdata;
      S_RB:    row_raddr = pair_rdata[2*AW-1:AW];
      S_RC:    row_raddr = pair_rdata[AW-1:0];
      default: row_raddr = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_MA:    ord_raddr = (p < mid) ? p[AW-1:0] : q[AW-1:0];
      S_MB:    ord_raddr = q[AW-1:0];
      S_JA:    ord_raddr = cnt[AW-1:0];
      default: ord_raddr = '0;
    endcase
  end

  // order buffer writes: seed goes to buffer a, merges to the other buffer
  always_comb begin
    ord_we    = 1'b0;
    ord_wsel  = !src_sel;
    ord_waddr = k[AW-1:0];
    ord_wdata = ord_rdata;
    case (state)
      S_INIT: begin
        ord_we    = cnt < rows_loaded;
        ord_wsel  = 1'b0;
        ord_waddr = cnt[AW-1:0];
        ord_wdata = cnt[AW-1:0];
      end
      S_CW: begin
        ord_we = 1'b1;
      end
      S_ME: begin
        ord_we    = 1'b1;
        ord_wdata = b_first ? idx_q : idx_p;
      end
      default: begin
        ord_we = 1'b0;
      end
    endcase
  end

  // scan pairs the latest left row with each right row of the same key
  assign pair_we    = (state == S_JC) && !row_rdata[PW] && left_seen &&
                      (row_rdata[RW-1 -: KEY_BITS] == cur_key);
  assign pair_waddr = pairs_found[AW-1:0];
  assign pair_wdata = {cur_idx, scan_idx};

  smkj_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  smkj_ram #(.WIDTH(AW), .DEPTH(MAX_ROWS)) u_ord_a_ram (
    .clk(clk), .we(ord_we && !ord_wsel), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_a_rdata)
  );

  smkj_ram #(.WIDTH(AW), .DEPTH(MAX_ROWS)) u_ord_b_ram (
    .clk(clk), .we(ord_we && ord_wsel), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_b_rdata)
  );

  smkj_ram #(.WIDTH(2*AW), .DEPTH(MAX_ROWS)) u_pair_ram (
    .clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
    .raddr(read_pointer[AW-1:0]), .rdata(pair_rdata)
  );

  // row p is registered, row q comes straight off the row ram
  smkj_cmp #(.KEY_BITS(KEY_BITS), .PW(PW), .AW(AW)) u_cmp (
    .key_a(row_p[RW-1 -: KEY_BITS]), .side_a(row_p[PW]), .pay_a(row_p[PW-1:0]),
    .idx_a(idx_p),
    .key_b(row_rdata[RW-1 -: KEY_BITS]), .side_b(row_rdata[PW]),
    .pay_b(row_rdata[PW-1:0]), .idx_b(idx_q),
    .b_first(b_first)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rows_loaded  <= '0;
      pairs_found  <= '0;
      read_pointer <= '0;
      joined       <= 1'b0;
      src_sel      <= 1'b0;
      copy_from_q  <= 1'b0;
      left_seen    <= 1'b0;
      cnt          <= '0;
      width        <= '0;
      lo           <= '0;
      mid          <= '0;
      hi           <= '0;
      p            <= '0;
      q            <= '0;
      k            <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (req.action == ACT_LOAD)) begin
            rows_loaded  <= base_rows + CW'(!full);
            read_pointer <= '0;
            joined       <= 1'b0;
            if (joined) begin
              pairs_found <= '0;
            end
            if (req.last_row) begin
              cnt   <= '0;
              state <= S_INIT;
            end
          end else if (accept && joined && (read_pointer < pairs_found)) begin
            state <= S_RA;
          end
        end
        S_INIT: begin
          if (cnt < rows_loaded) begin
            cnt <= cnt + 1'b1;
          end else begin
            src_sel     <= 1'b0;
            width       <= LW'(1);
            lo          <= '0;
            cnt         <= '0;
            left_seen   <= 1'b0;
            pairs_found <= '0;
            state       <= (rows_loaded <= CW'(1)) ? S_JA : S_PASS;
          end
        end
        S_PASS: begin
          if (lo >= n_l) begin
            // pass done, merged buffer becomes the source
            src_sel <= !src_sel;
            width   <= two_w;
            lo      <= '0;
            if (two_w >= n_l) begin
              state <= S_JA;
            end
          end else begin
            mid   <= (lo + width < n_l) ? lo + width : n_l;
            hi    <= (lo + two_w < n_l) ? lo + two_w : n_l;
            p     <= lo;
            q     <= (lo + width < n_l) ? lo + width : n_l;
            k     <= lo;
            state <= S_MA;
          end
        end
        S_MA: begin
          if ((p < mid) && (q < hi)) begin
            state <= S_MB;
          end else if (p < mid) begin
            copy_from_q <= 1'b0;
            state       <= S_CW;
          end else if (q < hi) begin
            copy_from_q <= 1'b1;
            state       <= S_CW;
          end else begin
            lo    <= lo + two_w;
            state <= S_PASS;
          end
        end
        S_CW: begin
          k <= k + 1'b1;
          if (copy_from_q) begin
            q <= q + 1'b1;
          end else begin
            p <= p + 1'b1;
          end
          state <= S_MA;
        end
        S_MB: begin
          state <= S_MC;
        end
        S_MC: begin
          state <= S_MD;
        end
        S_MD: begin
          state <= S_ME;
        end
        S_ME: begin
          k <= k + 1'b1;
          if (b_first) begin
            q <= q + 1'b1;
          end else begin
            p <= p + 1'b1;
          end
          state <= S_MA;
        end
        S_JA: begin
          if (cnt < rows_loaded) begin
            state <= S_JB;
          end else begin
            joined       <= 1'b1;
            read_pointer <= '0;
            state        <= S_IDLE;
          end
        end
        S_JB: begin
          state <= S_JC;
        end
        S_JC: begin
          if (row_rdata[PW]) begin
            left_seen <= 1'b1;
          end
          if (pair_we) begin
            pairs_found <= pairs_found + 1'b1;
          end
          cnt   <= cnt + 1'b1;
          state <= S_JA;
        end
        S_RA: begin
          state <= S_RB;
        end
        S_RB: begin
          state <= S_RC;
        end
        S_RC: begin
          state <= S_RD;
        end
        S_RD: begin
          read_pointer <= read_pointer + 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    case (state)
      S_MB:    idx_p <= ord_rdata;
      S_MC:    idx_q <= ord_rdata;
      S_MD:    row_p <= row_rdata;
      S_JB:    scan_idx <= ord_rdata;
      S_RC:    left_pay <= row_rdata[PW-1:0];
      default: idx_p <= idx_p;
    endcase
    if ((state == S_JC) && row_rdata[PW]) begin
      cur_idx <= scan_idx;
      cur_key <= row_rdata[RW-1 -: KEY_BITS];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((accept && !((req.action == ACT_READ) && joined &&
                 (read_pointer < pairs_found))) || (state == S_RD)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rsp.status        <= ST_MATCH;
      rsp.left_payload  <= 64'(left_pay);
      rsp.right_payload <= 64'(row_rdata[PW-1:0]);
      rsp.last_match    <= (read_pointer + 1'b1) == pairs_found;
    end else if (accept) begin
      rsp.left_payload  <= '0;
      rsp.right_payload <= '0;
      rsp.last_match    <= 1'b0;
      if (req.action == ACT_LOAD) begin
        rsp.status <= full ? ST_DROPPED : ST_ACCEPTED;
      end else begin
        rsp.status <= ST_NO_MORE;
      end
    end
  end

endmodule

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for the sort merge key join
// random row sets are loaded, joined and read back; every response is
// compared with a behavioral join kept in the bench
// ---------------------------------------------------------------------------
module tb;
  import smkj_pkg::*;

  localparam int unsigned ROWS      = DEF_MAX_ROWS;
  localparam int unsigned IDLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  in_t  req;
  logic rsp_valid;
  logic rsp_stall;
  out_t rsp;

  sort_merge_key_join dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // join state mirrored in the bench
  logic [31:0] set_key[ROWS];
  logic        set_left[ROWS];
  logic [63:0] set_payload[ROWS];
  int unsigned set_rows;
  logic [63:0] pair_left[$];
  logic [63:0] pair_right[$];
  int unsigned pair_ptr;
  logic        joined;

  in_t  pending_items[$];
  out_t expected_rsp[$];
  bit   failed;
  bit   stim_done;

  // true when row a sorts ahead of row b
  function automatic bit sorts_ahead(int unsigned a, int unsigned b);
    if (set_key[a] != set_key[b]) begin
      return $signed(set_key[a]) < $signed(set_key[b]);
    end
    if (set_left[a] != set_left[b]) begin
      return set_left[a];
    end
    if (set_payload[a] != set_payload[b]) begin
      return set_payload[a] < set_payload[b];
    end
    return a < b;
  endfunction

  // order is total, so any stable sort gives the same sequence
  task automatic build_pairs();
    int unsigned order[$];
    int unsigned tmp;
    int unsigned cur;
    bit          left_seen;
    int          j;
    left_seen = 0;
    cur = 0;
    for (int unsigned i = 0; i < set_rows; i++) begin
      order.push_back(i);
      j = int'(i);
      while (j > 0 && sorts_ahead(order[j], order[j-1])) begin
        tmp = order[j];
        order[j] = order[j-1];
        order[j-1] = tmp;
        j--;
      end
    end
    pair_left.delete();
    pair_right.delete();
    foreach (order[i]) begin
      if (set_left[order[i]]) begin
        cur = order[i];
        left_seen = 1;
      end else if (left_seen && set_key[cur] == set_key[order[i]] &&
                   pair_left.size() < ROWS) begin
        pair_left.push_back(set_payload[cur]);
        pair_right.push_back(set_payload[order[i]]);
      end
    end
    pair_ptr = 0;
    joined = 1;
  endtask

  // expected response of one accepted request
  task automatic join_step(input in_t item);
    out_t r;
    r = '0;
    if (item.action == ACT_LOAD) begin
      if (joined) begin
        set_rows = 0;
        pair_left.delete();
        pair_right.delete();
        pair_ptr = 0;
        joined = 0;
      end
      if (set_rows >= ROWS) begin
        r.status = ST_DROPPED;
      end else begin
        set_key[set_rows] = item.row_key;
        set_left[set_rows] = item.is_left;
        set_payload[set_rows] = item.row_payload;
        set_rows++;
        r.status = ST_ACCEPTED;
      end
      if (item.last_row) begin
        build_pairs();
      end
    end else if (joined && pair_ptr < pair_left.size()) begin
      r.status = ST_MATCH;
      r.left_payload = pair_left[pair_ptr];
      r.right_payload = pair_right[pair_ptr];
      r.last_match = (pair_ptr + 1 == pair_left.size());
      pair_ptr++;
    end else begin
      r.status = ST_NO_MORE;
    end
    expected_rsp.push_back(r);
  endtask

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic in_t make_load(logic signed [31:0] k, logic lft,
                                    logic [63:0] pl, logic lst);
    in_t t;
    t.action = ACT_LOAD;
    t.row_key = k;
    t.is_left = lft;
    t.row_payload = pl;
    t.last_row = lst;
    return t;
  endfunction

  function automatic in_t make_read();
    in_t t;
    t = '0;
    t.action = ACT_READ;
    t.row_key = $urandom;
    t.is_left = 1'($urandom_range(0, 1));
    t.row_payload = {$urandom, $urandom};
    t.last_row = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic logic [63:0] rand_payload();
    case ($urandom_range(0, 3))
      0: return 64'h0;
      1: return '1;
      2: return {56'h0, 8'($urandom_range(0, 3))};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_set(int unsigned n, int unsigned key_span, int unsigned reads);
    int signed base;
    base = $urandom_range(0, 1) ? int'($urandom) : 0;
    for (int unsigned i = 0; i < n; i++) begin
      pending_items.push_back(make_load(base + int'($urandom_range(0, key_span)),
                                        1'($urandom_range(0, 1)), rand_payload(),
                                        i == n - 1));
    end
    for (int unsigned i = 0; i < reads; i++) pending_items.push_back(make_read());
  endtask

  // stimulus
  initial begin
    int unsigned n;
    // directed: a read before any load, extremes, equal keys, no matches
    pending_items.push_back(make_read());
    pending_items.push_back(make_load(32'sh80000000, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b0));
    pending_items.push_back(make_load(32'sh80000000, 1'b0, 64'h0, 1'b0));
    pending_items.push_back(make_load(32'sh7fffffff, 1'b0, 64'h8000_0000_0000_0001, 1'b0));
    pending_items.push_back(make_load(32'sh7fffffff, 1'b1, 64'h0123_4567_89ab_cdef, 1'b0));
    pending_items.push_back(make_load(32'sh7fffffff, 1'b1, 64'h0000_0000_0000_0001, 1'b0));
    pending_items.push_back(make_load(-1, 1'b0, 64'h5555_5555_5555_5555, 1'b0));
    pending_items.push_back(make_load(-1, 1'b0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0));
    pending_items.push_back(make_load(-1, 1'b1, 64'h1, 1'b0));
    pending_items.push_back(make_load(0, 1'b0, 64'h2, 1'b1));
    for (int i = 0; i < 8; i++) pending_items.push_back(make_read());
    // right rows only: no pairs
    pending_items.push_back(make_load(5, 1'b0, 64'h7, 1'b0));
    pending_items.push_back(make_load(5, 1'b0, 64'h9, 1'b1));
    pending_items.push_back(make_read());
    pending_items.push_back(make_read());
    // random: mostly small sets with clustered keys
    while (pending_items.size() < 450) begin
      n = $urandom_range(1, 12);
      queue_set(n, $urandom_range(0, 4), $urandom_range(0, n + 3));
    end
    // one large set for long merge passes
    queue_set(300, 60, 30);
    while (pending_items.size() < 900) begin
      n = $urandom_range(1, 10);
      queue_set(n, $urandom_range(0, 3), $urandom_range(0, n + 2));
    end
  end

  // driver: one request transfer per accepting edge
  int unsigned req_gap;
  int unsigned rsp_hold;
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    stim_done = 0;
    failed = 0;
    set_rows = 0;
    pair_ptr = 0;
    joined = 0;
    req_gap = 0;
    rsp_hold = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        join_step(req);
        req_gap = gap_len();
      end
      if (req_valid && req_stall) begin
        // hold the stalled payload
      end else if (req_gap != 0) begin
        req_valid <= 1'b0;
        req_gap = req_gap - 1;
      end else if (pending_items.size() != 0) begin
        req_valid <= 1'b1;
        req <= pending_items.pop_front();
      end else begin
        req_valid <= 1'b0;
        stim_done = 1;
      end
    end
  end

  // monitor: compare each response transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected response %h", $time, rsp);
          failed = 1;
        end else begin
          out_t e;
          e = expected_rsp.pop_front();
          if (e.status != rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
            failed = 1;
          end
          if (e.left_payload != rsp.left_payload) begin
            $display("%0t: left_payload expected %h actual %h", $time,
                     e.left_payload, rsp.left_payload);
            failed = 1;
          end
          if (e.right_payload != rsp.right_payload) begin
            $display("%0t: right_payload expected %h actual %h", $time,
                     e.right_payload, rsp.right_payload);
            failed = 1;
          end
          if (e.last_match != rsp.last_match) begin
            $display("%0t: last_match expected %0d actual %0d", $time,
                     e.last_match, rsp.last_match);
            failed = 1;
          end
        end
      end
      // receiver stalls of random length, mostly short, a few long
      if (rsp_hold != 0) begin
        rsp_stall <= 1'b1;
        rsp_hold = rsp_hold - 1;
      end else begin
        rsp_stall <= 1'b0;
        if ($urandom_range(0, 99) < 30) rsp_hold = gap_len();
      end
    end
  end

  // watchdog and end of run
  int unsigned quiet_cycles;
  initial begin
    quiet_cycles = 0;
    @(negedge rst);
    while (!(stim_done && expected_rsp.size() == 0) && quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
    end else begin
      repeat (20) @(posedge clk);
      if (!failed) begin
        $display("tb: PASS");
      end else begin
        $display("tb: FAIL");
      end
    end
    $finish;
  end

endmodule

>>> sim.f
src/smkj_pkg.sv
src/smkj_ram.sv
src/smkj_cmp.sv
src/sort_merge_key_join.sv
tb/sv/tb.sv
